// ----- rtl/core/rbi2d_pkg.sv -----
// ----------------------------------------------------------------------------
// rbi2d_pkg
// Shared types, codes, saturation helper and microcode for the 2D integrator.
// ----------------------------------------------------------------------------
package rbi2d_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned SumW        = 36;
  localparam int unsigned DivSteps    = 9;
  localparam int unsigned DivBits     = 4;
  localparam logic [SumW-1:0] DivBias = 36'h6_0000_0000;
  localparam logic [SumW:0]   DivOffs = 37'h02_0000_0000;
  localparam int unsigned PcW         = 7;

  localparam logic [PcW-1:0] PcKin   = 7'd0;
  localparam logic [PcW-1:0] PcEul   = 7'd7;
  localparam logic [PcW-1:0] PcRk    = 7'd32;
  localparam logic [PcW-1:0] PcStage = 7'd33;

  localparam logic [1:0] KindKin = 2'd1;
  localparam logic [1:0] KindDyn = 2'd2;

  typedef enum logic [2:0] {
    CMD_FORCE  = 3'd0,
    CMD_TORQUE = 3'd1,
    CMD_STEP   = 3'd2,
    CMD_SLEEP  = 3'd3,
    CMD_POSE   = 3'd4,
    CMD_VEL    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_DT   = 3'd1,
    REG_GX   = 3'd2,
    REG_GY   = 3'd3,
    REG_INVM = 3'd4,
    REG_INVI = 3'd5,
    REG_LIN  = 3'd6,
    REG_ANG  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_MUL, OP_ADD, OP_SUB, OP_ACC, OP_DIV,
    OP_CLRK, OP_CLRF, OP_END, OP_SIMPLE
  } op_e;

  typedef enum logic [4:0] {
    SEL_ZERO, SEL_PX, SEL_PY, SEL_PA, SEL_VX, SEL_VY, SEL_W,
    SEL_AX, SEL_AY, SEL_AW, SEL_FX, SEL_FY, SEL_TQ, SEL_GX, SEL_GY,
    SEL_INVM, SEL_INVI, SEL_LIN, SEL_ANG, SEL_DT, SEL_H, SEL_T0, SEL_T1,
    SEL_KVX, SEL_KVY, SEL_KW, SEL_KAX, SEL_KAY, SEL_KAW, SEL_Q
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISP, ST_RUN, ST_DIV, ST_DONE
  } state_e;

  typedef struct packed {
    op_e        op;
    sel_e       dst;
    sel_e       src_a;
    sel_e       src_b;
    logic [2:0] idx;
  } uop_t;

  typedef struct packed {
    logic       load;
    uop_t       uop;
    logic [1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       sleeping;
    logic       div_done;
  } dp_stat_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [16:0]        dt;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [30:0]        invm;
    logic [30:0]        invi;
    logic [30:0]        lin;
    logic [30:0]        ang;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] spin_rate;
    logic               asleep;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [64:0] x);
    sat_t r;
    if (x > 65'sd2147483647) begin
      r.ovf = 1'b1;
      r.val = 32'sh7fff_ffff;
    end else if (x < -65'sd2147483648) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = x[31:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_e op, input sel_e d, input sel_e a,
                              input sel_e b, input logic [2:0] idx);
    uop_t u;
    u.op    = op;
    u.dst   = d;
    u.src_a = a;
    u.src_b = b;
    u.idx   = idx;
    return u;
  endfunction

  // Microcode: kinematic drift, semi-implicit Euler, and RK4 with a
  // four-pass stage loop followed by the weighted-average updates.
  function automatic uop_t urom(input logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(OP_MUL, SEL_T0, SEL_VX, SEL_DT, 3'd0);
      7'd1:  u = mk(OP_ADD, SEL_PX, SEL_PX, SEL_T0, 3'd0);
      7'd2:  u = mk(OP_MUL, SEL_T0, SEL_VY, SEL_DT, 3'd0);
      7'd3:  u = mk(OP_ADD, SEL_PY, SEL_PY, SEL_T0, 3'd0);
      7'd4:  u = mk(OP_MUL, SEL_T0, SEL_W, SEL_DT, 3'd0);
      7'd5:  u = mk(OP_ADD, SEL_PA, SEL_PA, SEL_T0, 3'd0);
      7'd6:  u = mk(OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
      7'd7:  u = mk(OP_ADD, SEL_T0, SEL_FX, SEL_GX, 3'd0);
      7'd8:  u = mk(OP_MUL, SEL_T1, SEL_VX, SEL_LIN, 3'd0);
      7'd9:  u = mk(OP_SUB, SEL_T0, SEL_T0, SEL_T1, 3'd0);
      7'd10: u = mk(OP_MUL, SEL_AX, SEL_T0, SEL_INVM, 3'd0);
      7'd11: u = mk(OP_ADD, SEL_T0, SEL_FY, SEL_GY, 3'd0);
      7'd12: u = mk(OP_MUL, SEL_T1, SEL_VY, SEL_LIN, 3'd0);
      7'd13: u = mk(OP_SUB, SEL_T0, SEL_T0, SEL_T1, 3'd0);
      7'd14: u = mk(OP_MUL, SEL_AY, SEL_T0, SEL_INVM, 3'd0);
      7'd15: u = mk(OP_MUL, SEL_T0, SEL_AX, SEL_DT, 3'd0);
      7'd16: u = mk(OP_ADD, SEL_VX, SEL_VX, SEL_T0, 3'd0);
      7'd17: u = mk(OP_MUL, SEL_T0, SEL_VX, SEL_DT, 3'd0);
      7'd18: u = mk(OP_ADD, SEL_PX, SEL_PX, SEL_T0, 3'd0);
      7'd19: u = mk(OP_MUL, SEL_T0, SEL_AY, SEL_DT, 3'd0);
      7'd20: u = mk(OP_ADD, SEL_VY, SEL_VY, SEL_T0, 3'd0);
      7'd21: u = mk(OP_MUL, SEL_T0, SEL_VY, SEL_DT, 3'd0);
      7'd22: u = mk(OP_ADD, SEL_PY, SEL_PY, SEL_T0, 3'd0);
      7'd23: u = mk(OP_MUL, SEL_T1, SEL_W, SEL_ANG, 3'd0);
      7'd24: u = mk(OP_SUB, SEL_T0, SEL_TQ, SEL_T1, 3'd0);
      7'd25: u = mk(OP_MUL, SEL_AW, SEL_T0, SEL_INVI, 3'd0);
      7'd26: u = mk(OP_MUL, SEL_T0, SEL_AW, SEL_DT, 3'd0);
      7'd27: u = mk(OP_ADD, SEL_W, SEL_W, SEL_T0, 3'd0);
      7'd28: u = mk(OP_MUL, SEL_T0, SEL_W, SEL_DT, 3'd0);
      7'd29: u = mk(OP_ADD, SEL_PA, SEL_PA, SEL_T0, 3'd0);
      7'd30: u = mk(OP_CLRF, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
      7'd31: u = mk(OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
      7'd32: u = mk(OP_CLRK, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
      7'd33: u = mk(OP_MUL, SEL_T0, SEL_KAX, SEL_H, 3'd0);
      7'd34: u = mk(OP_ADD, SEL_KVX, SEL_VX, SEL_T0, 3'd0);
      7'd35: u = mk(OP_MUL, SEL_T0, SEL_KAY, SEL_H, 3'd0);
      7'd36: u = mk(OP_ADD, SEL_KVY, SEL_VY, SEL_T0, 3'd0);
      7'd37: u = mk(OP_MUL, SEL_T0, SEL_KAW, SEL_H, 3'd0);
      7'd38: u = mk(OP_ADD, SEL_KW, SEL_W, SEL_T0, 3'd0);
      7'd39: u = mk(OP_ADD, SEL_T0, SEL_FX, SEL_GX, 3'd0);
      7'd40: u = mk(OP_MUL, SEL_T1, SEL_KVX, SEL_LIN, 3'd0);
      7'd41: u = mk(OP_SUB, SEL_T0, SEL_T0, SEL_T1, 3'd0);
      7'd42: u = mk(OP_MUL, SEL_KAX, SEL_T0, SEL_INVM, 3'd0);
      7'd43: u = mk(OP_ADD, SEL_T0, SEL_FY, SEL_GY, 3'd0);
      7'd44: u = mk(OP_MUL, SEL_T1, SEL_KVY, SEL_LIN, 3'd0);
      7'd45: u = mk(OP_SUB, SEL_T0, SEL_T0, SEL_T1, 3'd0);
      7'd46: u = mk(OP_MUL, SEL_KAY, SEL_T0, SEL_INVM, 3'd0);
      7'd47: u = mk(OP_MUL, SEL_T1, SEL_KW, SEL_ANG, 3'd0);
      7'd48: u = mk(OP_SUB, SEL_T0, SEL_TQ, SEL_T1, 3'd0);
      7'd49: u = mk(OP_MUL, SEL_KAW, SEL_T0, SEL_INVI, 3'd0);
      7'd50: u = mk(OP_ACC, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
      7'd51: u = mk(OP_DIV, SEL_Q, SEL_ZERO, SEL_ZERO, 3'd0);
      7'd52: u = mk(OP_MUL, SEL_T0, SEL_Q, SEL_DT, 3'd0);
      7'd53: u = mk(OP_ADD, SEL_PX, SEL_PX, SEL_T0, 3'd0);
      7'd54: u = mk(OP_DIV, SEL_Q, SEL_ZERO, SEL_ZERO, 3'd1);
      7'd55: u = mk(OP_MUL, SEL_T0, SEL_Q, SEL_DT, 3'd0);
      7'd56: u = mk(OP_ADD, SEL_PY, SEL_PY, SEL_T0, 3'd0);
      7'd57: u = mk(OP_DIV, SEL_Q, SEL_ZERO, SEL_ZERO, 3'd2);
      7'd58: u = mk(OP_MUL, SEL_T0, SEL_Q, SEL_DT, 3'd0);
      7'd59: u = mk(OP_ADD, SEL_PA, SEL_PA, SEL_T0, 3'd0);
      7'd60: u = mk(OP_DIV, SEL_Q, SEL_ZERO, SEL_ZERO, 3'd3);
      7'd61: u = mk(OP_ADD, SEL_AX, SEL_Q, SEL_ZERO, 3'd0);
      7'd62: u = mk(OP_MUL, SEL_T0, SEL_Q, SEL_DT, 3'd0);
      7'd63: u = mk(OP_ADD, SEL_VX, SEL_VX, SEL_T0, 3'd0);
      7'd64: u = mk(OP_DIV, SEL_Q, SEL_ZERO, SEL_ZERO, 3'd4);
      7'd65: u = mk(OP_ADD, SEL_AY, SEL_Q, SEL_ZERO, 3'd0);
      7'd66: u = mk(OP_MUL, SEL_T0, SEL_Q, SEL_DT, 3'd0);
      7'd67: u = mk(OP_ADD, SEL_VY, SEL_VY, SEL_T0, 3'd0);
      7'd68: u = mk(OP_DIV, SEL_Q, SEL_ZERO, SEL_ZERO, 3'd5);
      7'd69: u = mk(OP_ADD, SEL_AW, SEL_Q, SEL_ZERO, 3'd0);
      7'd70: u = mk(OP_MUL, SEL_T0, SEL_Q, SEL_DT, 3'd0);
      7'd71: u = mk(OP_ADD, SEL_W, SEL_W, SEL_T0, 3'd0);
      7'd72: u = mk(OP_CLRF, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
      default: u = mk(OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/rbi2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbi2d_ctrl
// Sequencer: dispatches each word and walks the microcode for step commands.
// ----------------------------------------------------------------------------
module rbi2d_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_busy_i,
  input  logic [3:0]         mode_i,
  input  rbi2d_pkg::dp_stat_t stat_i,
  output rbi2d_pkg::dp_cmd_t  cmd_o,
  output logic               in_stall_o,
  output logic               out_load_o
);
  import rbi2d_pkg::*;

  state_e          state_q, state_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic [1:0]      stage_q, stage_d;
  uop_t            u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      stage_q <= stage_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    stage_d      = stage_q;
    u            = urom(pc_q);
    cmd_o.load   = 1'b0;
    cmd_o.uop    = mk(OP_NOP, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
    cmd_o.stage  = stage_q;
    in_stall_o   = (state_q != ST_IDLE);
    out_load_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        stage_d = 2'd0;
        if (stat_i.cmd == CMD_STEP && !stat_i.sleeping && mode_i[1:0] == KindKin) begin
          pc_d    = PcKin;
          state_d = ST_RUN;
        end else if (stat_i.cmd == CMD_STEP && !stat_i.sleeping &&
                     mode_i[1:0] == KindDyn) begin
          pc_d    = mode_i[2] ? PcRk : PcEul;
          state_d = ST_RUN;
        end else begin
          cmd_o.uop = mk(OP_SIMPLE, SEL_ZERO, SEL_ZERO, SEL_ZERO, 3'd0);
          state_d   = ST_DONE;
        end
      end
      ST_RUN: begin
        cmd_o.uop = u;
        case (u.op)
          OP_DIV: begin
            pc_d    = pc_q + 7'd1;
            state_d = ST_DIV;
          end
          OP_ACC: begin
            if (stage_q != 2'd3) begin
              stage_d = stage_q + 2'd1;
              pc_d    = PcStage;
            end else begin
              pc_d = pc_q + 7'd1;
            end
          end
          OP_END:  state_d = ST_DONE;
          default: pc_d = pc_q + 7'd1;
        endcase
      end
      ST_DIV: begin
        if (stat_i.div_done) state_d = ST_RUN;
      end
      ST_DONE: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/rbi2d_dp.sv -----
// ----------------------------------------------------------------------------
// rbi2d_dp
// Body state, shared multiply/add/clamp unit, RK4 sums and divide-by-three.
// ----------------------------------------------------------------------------
module rbi2d_dp #(
  parameter int unsigned FRAC_BITS = rbi2d_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbi2d_pkg::cfg_t     cfg_i,
  input  logic [2:0]          command_i,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  scalar_i,
  input  rbi2d_pkg::dp_cmd_t  cmd_i,
  output rbi2d_pkg::dp_stat_t stat_o,
  output rbi2d_pkg::result_t  res_o
);
  import rbi2d_pkg::*;

  logic signed [31:0] px_q, py_q, pa_q, vx_q, vy_q, w_q, ax_q, ay_q, aw_q;
  logic signed [31:0] fx_q, fy_q, tq_q;
  logic               sleep_q, sat_q;
  logic [2:0]         cmd_q;
  logic signed [31:0] lx_q, ly_q, ls_q;
  logic signed [31:0] t0_q, t1_q, q_q, kvx_q, kvy_q, kw_q, kax_q, kay_q, kaw_q;
  logic signed [SumW-1:0] sum_q [6];
  logic               div_busy_q;
  logic [3:0]         div_cnt_q;
  logic [1:0]         div_rem_q;
  logic [SumW-1:0]    div_num_q, div_quo_q;

  logic signed [31:0] a_val, b_val, h_val;
  logic signed [63:0] prod;
  logic signed [64:0] prnd, pshift;
  logic signed [32:0] s_add, s_sub;
  sat_t               alu, fxs, fys, tqs, dq;
  logic signed [31:0] kvec [6];
  logic               dbl;
  logic signed [SumW-1:0] dsp, dy;
  logic [SumW-1:0]    dnum;
  logic [SumW:0]      dq37;
  logic [1:0]         r_n;
  logic [2:0]         t_n;
  logic [SumW-1:0]    n_n, q_n;
  logic               dyn, allow;

  function automatic logic signed [31:0] rd(input sel_e s);
    logic signed [31:0] v;
    case (s)
      SEL_PX:   v = px_q;
      SEL_PY:   v = py_q;
      SEL_PA:   v = pa_q;
      SEL_VX:   v = vx_q;
      SEL_VY:   v = vy_q;
      SEL_W:    v = w_q;
      SEL_AX:   v = ax_q;
      SEL_AY:   v = ay_q;
      SEL_AW:   v = aw_q;
      SEL_FX:   v = fx_q;
      SEL_FY:   v = fy_q;
      SEL_TQ:   v = tq_q;
      SEL_GX:   v = cfg_i.gx;
      SEL_GY:   v = cfg_i.gy;
      SEL_INVM: v = {1'b0, cfg_i.invm};
      SEL_INVI: v = {1'b0, cfg_i.invi};
      SEL_LIN:  v = {1'b0, cfg_i.lin};
      SEL_ANG:  v = {1'b0, cfg_i.ang};
      SEL_DT:   v = {15'd0, cfg_i.dt};
      SEL_H:    v = h_val;
      SEL_T0:   v = t0_q;
      SEL_T1:   v = t1_q;
      SEL_KVX:  v = kvx_q;
      SEL_KVY:  v = kvy_q;
      SEL_KW:   v = kw_q;
      SEL_KAX:  v = kax_q;
      SEL_KAY:  v = kay_q;
      SEL_KAW:  v = kaw_q;
      SEL_Q:    v = q_q;
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    case (cmd_i.stage)
      2'd0:    h_val = '0;
      2'd3:    h_val = {15'd0, cfg_i.dt};
      default: h_val = {16'd0, cfg_i.dt[16:1]};
    endcase
    a_val  = rd(cmd_i.uop.src_a);
    b_val  = rd(cmd_i.uop.src_b);
    // Round to nearest with ties upward, then floor shift.
    prod   = a_val * b_val;
    prnd   = 65'(prod) + (65'sd1 <<< (FRAC_BITS - 1));
    pshift = prnd >>> FRAC_BITS;
    s_add  = 33'(a_val) + 33'(b_val);
    s_sub  = 33'(a_val) - 33'(b_val);
    case (cmd_i.uop.op)
      OP_MUL:  alu = sat32(pshift);
      OP_ADD:  alu = sat32(65'(s_add));
      OP_SUB:  alu = sat32(65'(s_sub));
      default: alu = '0;
    endcase
    fxs = sat32(65'(33'(fx_q) + 33'(lx_q)));
    fys = sat32(65'(33'(fy_q) + 33'(ly_q)));
    tqs = sat32(65'(33'(tq_q) + 33'(ls_q)));
    dyn   = (cfg_i.mode[1:0] == KindDyn);
    allow = cfg_i.mode[3];
    kvec[0] = kvx_q;
    kvec[1] = kvy_q;
    kvec[2] = kw_q;
    kvec[3] = kax_q;
    kvec[4] = kay_q;
    kvec[5] = kaw_q;
    dbl = (cmd_i.stage == 2'd1) || (cmd_i.stage == 2'd2);
    // floor((s+3)/6) = floor(floor((s+3)/2)/3); a bias of 3*2^33 keeps it positive.
    dsp  = sum_q[cmd_i.uop.idx] + 36'sd3;
    dy   = dsp >>> 1;
    dnum = dy + DivBias;
    dq37 = {1'b0, div_quo_q} - DivOffs;
    dq   = sat32(65'($signed(dq37)));
    r_n = div_rem_q;
    n_n = div_num_q;
    q_n = div_quo_q;
    t_n = '0;
    for (int i = 0; i < DivBits; i++) begin
      t_n = {r_n, n_n[SumW-1]};
      n_n = n_n << 1;
      if (t_n >= 3'd3) begin
        r_n = 2'(t_n - 3'd3);
        q_n = {q_n[SumW-2:0], 1'b1};
      end else begin
        r_n = t_n[1:0];
        q_n = {q_n[SumW-2:0], 1'b0};
      end
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.sleeping = sleep_q;
  assign stat_o.div_done = div_busy_q && (div_cnt_q == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; pa_q <= '0;
      vx_q <= '0; vy_q <= '0; w_q <= '0;
      ax_q <= '0; ay_q <= '0; aw_q <= '0;
      fx_q <= '0; fy_q <= '0; tq_q <= '0;
      sleep_q    <= 1'b0;
      sat_q      <= 1'b0;
      cmd_q      <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cmd_q <= command_i;
        sat_q <= 1'b0;
      end
      case (cmd_i.uop.op)
        OP_MUL, OP_ADD, OP_SUB: begin
          if (alu.ovf) sat_q <= 1'b1;
          case (cmd_i.uop.dst)
            SEL_PX:  px_q <= alu.val;
            SEL_PY:  py_q <= alu.val;
            SEL_PA:  pa_q <= alu.val;
            SEL_VX:  vx_q <= alu.val;
            SEL_VY:  vy_q <= alu.val;
            SEL_W:   w_q  <= alu.val;
            SEL_AX:  ax_q <= alu.val;
            SEL_AY:  ay_q <= alu.val;
            SEL_AW:  aw_q <= alu.val;
            default: ;
          endcase
        end
        OP_CLRF: begin
          fx_q <= '0; fy_q <= '0; tq_q <= '0;
        end
        OP_DIV: begin
          div_busy_q <= 1'b1;
          div_cnt_q  <= 4'(DivSteps);
        end
        OP_SIMPLE: begin
          case (cmd_q)
            CMD_FORCE: begin
              if (dyn) begin
                fx_q <= fxs.val;
                fy_q <= fys.val;
                if (fxs.ovf || fys.ovf) sat_q <= 1'b1;
                if (allow) sleep_q <= 1'b0;
              end
            end
            CMD_TORQUE: begin
              if (dyn) begin
                tq_q <= tqs.val;
                if (tqs.ovf) sat_q <= 1'b1;
                if (allow) sleep_q <= 1'b0;
              end
            end
            CMD_STEP: begin
              if (sleep_q) begin
                fx_q <= '0; fy_q <= '0; tq_q <= '0;
              end else begin
                vx_q <= '0; vy_q <= '0; w_q <= '0;
              end
            end
            CMD_SLEEP: begin
              if (allow) sleep_q <= 1'b1;
            end
            CMD_POSE: begin
              px_q <= lx_q; py_q <= ly_q; pa_q <= ls_q;
            end
            CMD_VEL: begin
              vx_q <= lx_q; vy_q <= ly_q; w_q <= ls_q;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (div_busy_q) begin
        if (div_cnt_q != 4'd0) begin
          div_cnt_q <= div_cnt_q - 4'd1;
        end else begin
          div_busy_q <= 1'b0;
          if (dq.ovf) sat_q <= 1'b1;
        end
      end
    end
  end

  // Scratch registers: inputs, stage values, sums and divider data path.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lx_q <= vec_x_i;
      ly_q <= vec_y_i;
      ls_q <= scalar_i;
    end
    case (cmd_i.uop.op)
      OP_MUL, OP_ADD, OP_SUB: begin
        case (cmd_i.uop.dst)
          SEL_T0:  t0_q  <= alu.val;
          SEL_T1:  t1_q  <= alu.val;
          SEL_KVX: kvx_q <= alu.val;
          SEL_KVY: kvy_q <= alu.val;
          SEL_KW:  kw_q  <= alu.val;
          SEL_KAX: kax_q <= alu.val;
          SEL_KAY: kay_q <= alu.val;
          SEL_KAW: kaw_q <= alu.val;
          default: ;
        endcase
      end
      OP_CLRK: begin
        kax_q <= '0; kay_q <= '0; kaw_q <= '0;
        for (int k = 0; k < 6; k++) sum_q[k] <= '0;
      end
      OP_ACC: begin
        for (int k = 0; k < 6; k++) begin
          sum_q[k] <= sum_q[k] + (dbl ? (SumW'(kvec[k]) <<< 1) : SumW'(kvec[k]));
        end
      end
      OP_DIV: begin
        div_num_q <= dnum;
        div_rem_q <= '0;
        div_quo_q <= '0;
      end
      default: ;
    endcase
    if (div_busy_q) begin
      if (div_cnt_q != 4'd0) begin
        div_num_q <= n_n;
        div_rem_q <= r_n;
        div_quo_q <= q_n;
      end else begin
        q_q <= dq.val;
      end
    end
  end

  assign res_o.pos_x     = px_q;
  assign res_o.pos_y     = py_q;
  assign res_o.angle     = pa_q;
  assign res_o.vel_x     = vx_q;
  assign res_o.vel_y     = vy_q;
  assign res_o.spin      = w_q;
  assign res_o.acc_x     = ax_q;
  assign res_o.acc_y     = ay_q;
  assign res_o.spin_rate = aw_q;
  assign res_o.asleep    = sleep_q;
  assign res_o.saturated = sat_q;

endmodule

// ----- rtl/core/rigid_body_integrator_2d.sv -----
// ----------------------------------------------------------------------------
// rigid_body_integrator_2d
// One 2D rigid body in fixed point: force accumulation, kinematic, Euler or RK4 steps.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Content
//  in      | input     | in_valid_i/in_stall_o | command, vec_x, vec_y, scalar
//  out     | output    | out_valid_o/out_stall_i | full body state, flags
//  cfg     | input     | cfg_we_i              | register index and data
//
// Force, torque, sleep, load and trivial step words pass from acceptance
// through the dispatch and done states to a ready result. Kinematic, Euler
// and RK4 steps walk their microcode in the run state: the single shared
// multiply/add unit executes one microcode operation per cycle outside the
// divider waits; each of the six RK4 averages waits on the radix-16 divider.
// Reset clears the body state and loads the register defaults at once.
// A new word is taken while a finished result still waits in the output
// register; the sequencer only stalls when that result must be replaced.
module rigid_body_integrator_2d #(
  parameter int unsigned FRAC_BITS = rbi2d_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         in_command_i,
  input  logic signed [31:0] in_vec_x_i,
  input  logic signed [31:0] in_vec_y_i,
  input  logic signed [31:0] in_scalar_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_angle_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic signed [31:0] out_spin_o,
  output logic signed [31:0] out_acc_x_o,
  output logic signed [31:0] out_acc_y_o,
  output logic signed [31:0] out_spin_rate_o,
  output logic               out_asleep_out_o,
  output logic               out_saturated_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import rbi2d_pkg::*;

  cfg_t      cfg_q;
  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  result_t   dp_res, res_q;
  logic      out_valid_q;
  logic      out_load;
  logic      out_busy;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= 4'd10;
      cfg_q.dt   <= 17'd1092;
      cfg_q.gx   <= '0;
      cfg_q.gy   <= '0;
      cfg_q.invm <= 31'd65536;
      cfg_q.invi <= 31'd65536;
      cfg_q.lin  <= '0;
      cfg_q.ang  <= 31'd655;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MODE: cfg_q.mode <= cfg_data_i[3:0];
        REG_DT:   cfg_q.dt   <= cfg_data_i[16:0];
        REG_GX:   cfg_q.gx   <= cfg_data_i;
        REG_GY:   cfg_q.gy   <= cfg_data_i;
        REG_INVM: cfg_q.invm <= cfg_data_i[30:0];
        REG_INVI: cfg_q.invi <= cfg_data_i[30:0];
        REG_LIN:  cfg_q.lin  <= cfg_data_i[30:0];
        REG_ANG:  cfg_q.ang  <= cfg_data_i[30:0];
        default:  ;
      endcase
    end
  end

  // The output register is busy while a word sits there and is stalled.
  assign out_busy = out_valid_q && out_stall_i;

  rbi2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .mode_i     (cfg_q.mode),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd),
    .in_stall_o (in_stall_o),
    .out_load_o (out_load)
  );

  rbi2d_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .command_i (in_command_i),
    .vec_x_i   (in_vec_x_i),
    .vec_y_i   (in_vec_y_i),
    .scalar_i  (in_scalar_i),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .res_o     (dp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= dp_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_pos_x_o      = res_q.pos_x;
  assign out_pos_y_o      = res_q.pos_y;
  assign out_angle_o      = res_q.angle;
  assign out_vel_x_o      = res_q.vel_x;
  assign out_vel_y_o      = res_q.vel_y;
  assign out_spin_o       = res_q.spin;
  assign out_acc_x_o      = res_q.acc_x;
  assign out_acc_y_o      = res_q.acc_y;
  assign out_spin_rate_o  = res_q.spin_rate;
  assign out_asleep_out_o = res_q.asleep;
  assign out_saturated_o  = res_q.saturated;

  // A finished result never overwrites a word that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a stalled output word");

  // Once a word is taken, the input stays stalled while it is processed.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // A new output word only appears after the sequencer loaded one.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(out_load))
    else $error("output valid rose without a result load");

endmodule

// ----- bench/tb_rigid_body_integrator_2d.sv -----
// ----------------------------------------------------------------------------
// tb_rigid_body_integrator_2d
// Self-checking bench for the 2D rigid body integrator. A driver feeds command
// words from a queue, a monitor compares every result word field by field
// with the state that the bench's own body model predicts, and the register
// file is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rigid_body_integrator_2d;
  import rbi2d_pkg::*;

  localparam int unsigned Frac     = 16;
  localparam longint      MaxCycle = 3_000_000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] sc;
  } word_t;

  typedef struct {
    int vx, vy, w, ax, ay, aw;
  } slope_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] in_command_i = '0;
  logic signed [31:0] in_vec_x_i = '0, in_vec_y_i = '0, in_scalar_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_angle_o, out_vel_x_o, out_vel_y_o;
  logic signed [31:0] out_spin_o, out_acc_x_o, out_acc_y_o, out_spin_rate_o;
  logic out_asleep_out_o, out_saturated_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  rigid_body_integrator_2d dut (.*);

  // Register shadow of the body model.
  logic [3:0] m_mode;
  longint m_dt, m_gx, m_gy, m_invm, m_invi, m_lin, m_ang;
  // Body state of the model.
  int b_px, b_py, b_pa, b_vx, b_vy, b_w, b_ax, b_ay, b_aw, b_fx, b_fy, b_tq;
  bit b_sleep, b_clamp;

  word_t   pending_words[$];
  result_t expected_states[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycle = 0;

  // Arithmetic helpers: every result is clamped to the 32-bit signed range,
  // and any clamp marks the word as saturated.
  function automatic int clip(longint x);
    if (x > 64'sd2147483647) begin
      b_clamp = 1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      b_clamp = 1;
      return 32'sh80000000;
    end
    return int'(x);
  endfunction

  function automatic int fmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (Frac - 1));
    return clip(p >>> Frac);
  endfunction

  function automatic int avg6(longint a, longint b, longint c, longint d);
    longint s, q;
    s = a + 2 * (b + c) + d + 3;
    q = (s >= 0) ? s / 6 : -((-s + 5) / 6);
    return clip(q);
  endfunction

  function automatic slope_t rk_stage(longint h, slope_t p);
    slope_t o;
    o.vx = clip(longint'(b_vx) + fmul(p.ax, h));
    o.vy = clip(longint'(b_vy) + fmul(p.ay, h));
    o.w  = clip(longint'(b_w) + fmul(p.aw, h));
    o.ax = fmul(clip(longint'(clip(longint'(b_fx) + m_gx)) - fmul(o.vx, m_lin)), m_invm);
    o.ay = fmul(clip(longint'(clip(longint'(b_fy) + m_gy)) - fmul(o.vy, m_lin)), m_invm);
    o.aw = fmul(clip(longint'(b_tq) - fmul(o.w, m_ang)), m_invi);
    return o;
  endfunction

  task automatic step_body();
    slope_t z, a, b, c, d;
    int qx, qy, qa, rx, ry, rw;
    if (b_sleep) begin
      b_fx = 0; b_fy = 0; b_tq = 0;
      return;
    end
    if (m_mode[1:0] == KindKin) begin
      b_px = clip(longint'(b_px) + fmul(b_vx, m_dt));
      b_py = clip(longint'(b_py) + fmul(b_vy, m_dt));
      b_pa = clip(longint'(b_pa) + fmul(b_w, m_dt));
      return;
    end
    if (m_mode[1:0] != KindDyn) begin
      // Static bodies, and the unused fourth kind, lose their velocity.
      b_vx = 0; b_vy = 0; b_w = 0;
      return;
    end
    if (m_mode[2]) begin
      z = '{0, 0, 0, 0, 0, 0};
      a = rk_stage(0, z);
      b = rk_stage(m_dt >>> 1, a);
      c = rk_stage(m_dt >>> 1, b);
      d = rk_stage(m_dt, c);
      qx = avg6(a.vx, b.vx, c.vx, d.vx);
      qy = avg6(a.vy, b.vy, c.vy, d.vy);
      qa = avg6(a.w, b.w, c.w, d.w);
      rx = avg6(a.ax, b.ax, c.ax, d.ax);
      ry = avg6(a.ay, b.ay, c.ay, d.ay);
      rw = avg6(a.aw, b.aw, c.aw, d.aw);
      b_px = clip(longint'(b_px) + fmul(qx, m_dt));
      b_py = clip(longint'(b_py) + fmul(qy, m_dt));
      b_pa = clip(longint'(b_pa) + fmul(qa, m_dt));
      b_vx = clip(longint'(b_vx) + fmul(rx, m_dt));
      b_vy = clip(longint'(b_vy) + fmul(ry, m_dt));
      b_w  = clip(longint'(b_w) + fmul(rw, m_dt));
      b_ax = rx; b_ay = ry; b_aw = rw;
    end else begin
      b_ax = fmul(clip(longint'(clip(longint'(b_fx) + m_gx)) - fmul(b_vx, m_lin)), m_invm);
      b_ay = fmul(clip(longint'(clip(longint'(b_fy) + m_gy)) - fmul(b_vy, m_lin)), m_invm);
      b_vx = clip(longint'(b_vx) + fmul(b_ax, m_dt));
      b_vy = clip(longint'(b_vy) + fmul(b_ay, m_dt));
      b_px = clip(longint'(b_px) + fmul(b_vx, m_dt));
      b_py = clip(longint'(b_py) + fmul(b_vy, m_dt));
      b_aw = fmul(clip(longint'(b_tq) - fmul(b_w, m_ang)), m_invi);
      b_w  = clip(longint'(b_w) + fmul(b_aw, m_dt));
      b_pa = clip(longint'(b_pa) + fmul(b_w, m_dt));
    end
    b_fx = 0; b_fy = 0; b_tq = 0;
  endtask

  // Apply one accepted command word to the model and queue the state it leaves.
  task automatic predict_state(word_t wd);
    bit dyn, allow;
    result_t r;
    dyn   = (m_mode[1:0] == KindDyn);
    allow = m_mode[3];
    b_clamp = 0;
    case (wd.cmd)
      CMD_FORCE: if (dyn) begin
        b_fx = clip(longint'(b_fx) + wd.vx);
        b_fy = clip(longint'(b_fy) + wd.vy);
        if (allow) b_sleep = 0;
      end
      CMD_TORQUE: if (dyn) begin
        b_tq = clip(longint'(b_tq) + wd.sc);
        if (allow) b_sleep = 0;
      end
      CMD_STEP: step_body();
      CMD_SLEEP: if (allow) b_sleep = 1;
      CMD_POSE: begin
        b_px = wd.vx; b_py = wd.vy; b_pa = wd.sc;
      end
      CMD_VEL: begin
        b_vx = wd.vx; b_vy = wd.vy; b_w = wd.sc;
      end
      default: ;
    endcase
    r = '{b_px, b_py, b_pa, b_vx, b_vy, b_w, b_ax, b_ay, b_aw, b_sleep, b_clamp};
    expected_states.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, field, got, want);
    errors++;
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle <= cycle + 1;

  // Driver: a word stays on the port until the block takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_state(pending_words.pop_front());
      end
      if ((in_valid_i && in_stall_o) ||
          (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
        if (!(in_valid_i && in_stall_o)) begin
          in_valid_i   <= (pending_words.size() > 0);
          in_command_i <= pending_words[0].cmd;
          in_vec_x_i   <= pending_words[0].vx;
          in_vec_y_i   <= pending_words[0].vy;
          in_scalar_i  <= pending_words[0].sc;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken result word with the oldest prediction.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_states.size() == 0) begin
          $display("unexpected result word at cycle %0d", cycle);
          errors++;
        end else begin
          e = expected_states.pop_front();
          if (out_pos_x_o != e.pos_x) report_mismatch("pos_x", out_pos_x_o, e.pos_x);
          if (out_pos_y_o != e.pos_y) report_mismatch("pos_y", out_pos_y_o, e.pos_y);
          if (out_angle_o != e.angle) report_mismatch("angle", out_angle_o, e.angle);
          if (out_vel_x_o != e.vel_x) report_mismatch("vel_x", out_vel_x_o, e.vel_x);
          if (out_vel_y_o != e.vel_y) report_mismatch("vel_y", out_vel_y_o, e.vel_y);
          if (out_spin_o != e.spin) report_mismatch("spin", out_spin_o, e.spin);
          if (out_acc_x_o != e.acc_x) report_mismatch("acc_x", out_acc_x_o, e.acc_x);
          if (out_acc_y_o != e.acc_y) report_mismatch("acc_y", out_acc_y_o, e.acc_y);
          if (out_spin_rate_o != e.spin_rate)
            report_mismatch("spin_rate", out_spin_rate_o, e.spin_rate);
          if (out_asleep_out_o != e.asleep)
            report_mismatch("asleep", out_asleep_out_o, e.asleep);
          if (out_saturated_o != e.saturated)
            report_mismatch("saturated", out_saturated_o, e.saturated);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    if (cycle > MaxCycle) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // A register write happens only with the block idle; the model follows.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE: m_mode = val[3:0];
      REG_DT:   m_dt = val[16:0];
      REG_GX:   m_gx = longint'(signed'(val));
      REG_GY:   m_gy = longint'(signed'(val));
      REG_INVM: m_invm = val[30:0];
      REG_INVI: m_invi = val[30:0];
      REG_LIN:  m_lin = val[30:0];
      REG_ANG:  m_ang = val[30:0];
      default: ;
    endcase
  endtask

  task automatic add_word(logic [2:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] s);
    pending_words.push_back('{c, x, y, s});
  endtask

  // Wait for every queued word to be taken and answered.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_states.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Mostly force/torque/step sequences with random content, plus noise.
  task automatic random_words(int n);
    logic [2:0] c;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2: c = CMD_FORCE;
        3, 4:    c = CMD_TORQUE;
        5, 6:    c = CMD_STEP;
        7:       c = CMD_SLEEP;
        8:       c = $urandom_range(1) ? CMD_POSE : CMD_VEL;
        default: c = 3'($urandom_range(7));
      endcase
      pending_words.push_back('{c, rand_q(), rand_q(), rand_q()});
    end
  endtask

  initial begin
    m_mode = 4'd10; m_dt = 1092; m_gx = 0; m_gy = 0;
    m_invm = 65536; m_invi = 65536; m_lin = 0; m_ang = 655;
    {b_px, b_py, b_pa, b_vx, b_vy, b_w, b_ax, b_ay, b_aw, b_fx, b_fy, b_tq} = '0;
    b_sleep = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset registers: Euler, dynamic, sleep allowed.
    add_word(CMD_FORCE, 32'h7fffffff, 32'h80000000, 0);
    add_word(CMD_FORCE, 32'h7fffffff, 32'h80000000, 0);
    add_word(CMD_TORQUE, 0, 0, 32'h80000000);
    add_word(CMD_STEP, 0, 0, 0);
    add_word(CMD_SLEEP, 0, 0, 0);
    add_word(CMD_FORCE, 32'h10000, 32'h10000, 0);
    add_word(CMD_SLEEP, 0, 0, 0);
    add_word(CMD_TORQUE, 0, 0, 32'h10000);
    add_word(CMD_SLEEP, 0, 0, 0);
    add_word(CMD_POSE, 32'h80000000, 32'h7fffffff, 32'h12345);
    add_word(CMD_STEP, 0, 0, 0);
    add_word(CMD_VEL, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_word(CMD_FORCE, 32'hffff0000, 32'h30000, 0);
    add_word(CMD_STEP, 0, 0, 0);
    add_word(3'd6, 1, 2, 3);
    add_word(3'd7, 1, 2, 3);
    drain();

    // Phases of registers, each with random words under an idling pattern.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      write_reg(REG_MODE, (ph < 8) ? ph + 8 : $urandom_range(15));
      write_reg(REG_DT, (ph == 1) ? 0 : (ph == 2) ? 65536 : $urandom_range(4096));
      write_reg(REG_GX, (ph == 3) ? 32'h80000000 : rand_q());
      write_reg(REG_GY, (ph == 3) ? 32'h7fffffff : $urandom_range(65536) - 32768);
      write_reg(REG_INVM, (ph == 4) ? 32'h7fffffff : (ph == 5) ? 0 : $urandom_range(131072));
      write_reg(REG_INVI, (ph == 4) ? 32'h7fffffff : (ph == 5) ? 0 : $urandom_range(131072));
      write_reg(REG_LIN, (ph == 6) ? 32'h7fffffff : $urandom_range(8192));
      write_reg(REG_ANG, (ph == 6) ? 32'h7fffffff : $urandom_range(8192));
      random_words(55);
      // Hold the sender off until every result of the first half is back.
      drain();
      random_words(55);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rbi2d_pkg.sv
rtl/core/rbi2d_ctrl.sv
rtl/core/rbi2d_dp.sv
rtl/core/rigid_body_integrator_2d.sv
bench/tb_rigid_body_integrator_2d.sv
